/* rtl/bed_pkg.sv */
// shared types, constants and decode helpers of the backslash escape decoder
`default_nettype none

package bed_pkg;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_BSL,
    MODE_OCT,
    MODE_HEX,
    MODE_DROP
  } bed_mode_e;

  localparam logic [7:0] CharBsl  = 8'h5C;
  localparam logic [7:0] CharA    = 8'h61;
  localparam logic [7:0] CharB    = 8'h62;
  localparam logic [7:0] CharC    = 8'h63;
  localparam logic [7:0] CharF    = 8'h66;
  localparam logic [7:0] CharN    = 8'h6E;
  localparam logic [7:0] CharR    = 8'h72;
  localparam logic [7:0] CharT    = 8'h74;
  localparam logic [7:0] CharV    = 8'h76;
  localparam logic [7:0] CharX    = 8'h78;
  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharSeven = 8'h37;
  localparam logic [7:0] CharNine = 8'h39;
  localparam logic [7:0] CharUpA  = 8'h41;
  localparam logic [7:0] CharUpF  = 8'h46;
  localparam logic [7:0] CharLoF  = 8'h66;

  localparam logic [7:0] CtlBel = 8'h07;
  localparam logic [7:0] CtlBs  = 8'h08;
  localparam logic [7:0] CtlTab = 8'h09;
  localparam logic [7:0] CtlLf  = 8'h0A;
  localparam logic [7:0] CtlVt  = 8'h0B;
  localparam logic [7:0] CtlFf  = 8'h0C;
  localparam logic [7:0] CtlCr  = 8'h0D;

  // one queue entry: the bytes caused by one input transfer
  typedef struct packed {
    logic       pair;
    logic [7:0] byte1;
    logic [7:0] byte0;
  } bed_entry_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] value;
  } bed_esc_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] value;
  } bed_hex_t;

  function automatic bed_esc_t simple_escape(input logic [7:0] b);
    bed_esc_t r;
    r.hit = 1'b1;
    unique case (b)
      CharBsl: r.value = CharBsl;
      CharA:   r.value = CtlBel;
      CharB:   r.value = CtlBs;
      CharF:   r.value = CtlFf;
      CharN:   r.value = CtlLf;
      CharR:   r.value = CtlCr;
      CharT:   r.value = CtlTab;
      CharV:   r.value = CtlVt;
      default: begin
        r.hit   = 1'b0;
        r.value = 8'h00;
      end
    endcase
    return r;
  endfunction

  function automatic bed_hex_t hex_digit(input logic [7:0] b);
    bed_hex_t r;
    r.hit   = 1'b1;
    r.value = 4'h0;
    if (b >= CharZero && b <= CharNine) begin
      r.value = 4'(b - CharZero);
    end else if (b >= CharA && b <= CharLoF) begin
      r.value = 4'(b - CharA + 8'd10);
    end else if (b >= CharUpA && b <= CharUpF) begin
      r.value = 4'(b - CharUpA + 8'd10);
    end else begin
      r.hit = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/backslash_escape_decoder.sv */
// top level of the backslash escape decoder
`default_nettype none

// Decodes backslash escapes of one argument string, one byte per input
// transfer, with tlast on the last byte of the argument. With the config bit
// set, \\ \a \b \f \n \r \t \v, \c (drop rest of argument), \0 with up to
// three octal digits and \x with up to two hex digits are decoded; with it
// clear, bytes pass through. Each input gives zero, one or two output bytes;
// tlast marks the last byte caused by that input. The input side accepts one
// byte per clock while the four-entry queue has room; the output side sends
// one byte per clock while the receiver is ready, so an input that yields two
// bytes occupies the output for both of them and the output port sets the
// sustained rate. A byte passes through a queue entry and the output register
// before it leaves. Write the config bit only while the block is idle.
module backslash_escape_decoder (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic       cfg_data_i,     // interpret_escapes
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  wire logic       s_axis_tlast,   // arg_end
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
  output logic            m_axis_tlast    // run_last
);
  import bed_pkg::*;

  logic       push, pop, full, empty;
  bed_entry_t push_entry, head;

  assign cfg_ready_o = 1'b1;

  bed_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (s_axis_tvalid),
    .in_byte_i    (s_axis_tdata),
    .in_end_i     (s_axis_tlast),
    .full_i       (full),
    .in_ready_o   (s_axis_tready),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  bed_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .full_o       (full),
    .empty_o      (empty),
    .head_o       (head)
  );

  bed_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire

/* rtl/bed_front.sv */
// front end: accepts input bytes, tracks escape state and forms queue entries
`default_nettype none

module bed_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  input  wire logic               cfg_data_i,
  input  wire logic               in_valid_i,
  input  wire logic [7:0]         in_byte_i,
  input  wire logic               in_end_i,
  input  wire logic               full_i,
  output logic                    in_ready_o,
  output logic                    push_o,
  output bed_pkg::bed_entry_t     push_entry_o
);
  import bed_pkg::*;

  logic      esc_q;
  bed_mode_e mode_q, mode_d;
  logic [7:0] val_q, val_d;
  logic [1:0] cnt_q, cnt_d;

  logic [1:0] n;
  logic [7:0] o0, o1;
  logic       take;
  bed_esc_t   esc;
  bed_hex_t   hex;
  logic       oct_hit;

  assign in_ready_o = !full_i;
  assign take       = in_valid_i && !full_i;
  assign esc        = simple_escape(in_byte_i);
  assign hex        = hex_digit(in_byte_i);
  assign oct_hit    = (in_byte_i >= CharZero) && (in_byte_i <= CharSeven);

  always_comb begin
    mode_d = mode_q;
    val_d  = val_q;
    cnt_d  = cnt_q;
    n      = 2'd0;
    o0     = 8'h00;
    o1     = 8'h00;
    if (!esc_q) begin
      // flush anything pending, then the raw byte
      if (mode_q == MODE_BSL) begin
        o0 = CharBsl;
        n  = 2'd1;
      end else if (mode_q == MODE_OCT || mode_q == MODE_HEX) begin
        o0 = val_q;
        n  = 2'd1;
      end
      if (n == 2'd0) o0 = in_byte_i;
      else           o1 = in_byte_i;
      n      = n + 2'd1;
      mode_d = MODE_IDLE;
      val_d  = 8'h00;
      cnt_d  = 2'd0;
    end else begin
      unique case (mode_q)
        MODE_BSL: begin
          mode_d = MODE_IDLE;
          val_d  = 8'h00;
          cnt_d  = 2'd0;
          if (esc.hit) begin
            o0 = esc.value;
            n  = 2'd1;
          end else if (in_byte_i == CharC) begin
            mode_d = MODE_DROP;
          end else if (in_byte_i == CharX) begin
            mode_d = MODE_HEX;
          end else if (in_byte_i == CharZero) begin
            mode_d = MODE_OCT;
          end else begin
            o0 = CharBsl;
            o1 = in_byte_i;
            n  = 2'd2;
          end
        end
        MODE_OCT, MODE_HEX: begin
          if ((mode_q == MODE_OCT && oct_hit) || (mode_q == MODE_HEX && hex.hit)) begin
            if (mode_q == MODE_OCT) val_d = {val_q[4:0], in_byte_i[2:0]};
            else                    val_d = {val_q[3:0], hex.value};
            cnt_d = cnt_q + 2'd1;
            if ((mode_q == MODE_OCT && cnt_d == 2'd3) ||
                (mode_q == MODE_HEX && cnt_d == 2'd2)) begin
              o0     = val_d;
              n      = 2'd1;
              mode_d = MODE_IDLE;
              val_d  = 8'h00;
              cnt_d  = 2'd0;
            end
          end else begin
            o0     = val_q;
            n      = 2'd1;
            mode_d = MODE_IDLE;
            val_d  = 8'h00;
            cnt_d  = 2'd0;
            if (in_byte_i == CharBsl) begin
              mode_d = MODE_BSL;
            end else begin
              o1 = in_byte_i;
              n  = 2'd2;
            end
          end
        end
        MODE_DROP: begin
        end
        default: begin
          mode_d = MODE_IDLE;
          val_d  = 8'h00;
          cnt_d  = 2'd0;
          if (in_byte_i == CharBsl) begin
            mode_d = MODE_BSL;
          end else begin
            o0 = in_byte_i;
            n  = 2'd1;
          end
        end
      endcase
      if (in_end_i) begin
        // close an open sequence at the end of the argument
        if (mode_d == MODE_BSL || mode_d == MODE_OCT || mode_d == MODE_HEX) begin
          if (n == 2'd0) o0 = (mode_d == MODE_BSL) ? CharBsl : val_d;
          else           o1 = (mode_d == MODE_BSL) ? CharBsl : val_d;
          n = n + 2'd1;
        end
        mode_d = MODE_IDLE;
        val_d  = 8'h00;
        cnt_d  = 2'd0;
      end
    end
  end

  assign push_o             = take && (n != 2'd0);
  assign push_entry_o.pair  = (n == 2'd2);
  assign push_entry_o.byte0 = o0;
  assign push_entry_o.byte1 = o1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q  <= 1'b0;
      mode_q <= MODE_IDLE;
      val_q  <= 8'h00;
      cnt_q  <= 2'd0;
    end else begin
      if (cfg_valid_i) esc_q <= cfg_data_i;
      if (take) begin
        mode_q <= mode_d;
        val_q  <= val_d;
        cnt_q  <= cnt_d;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q != MODE_OCT && mode_q != MODE_HEX) |-> (cnt_q == 2'd0 && val_q == 8'h00))
    else $error("digit state left over outside a numeric escape");
  a_oct_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_OCT) |-> (cnt_q != 2'd3))
    else $error("octal escape holds three digits");
  a_hex_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_HEX) |-> (cnt_q == 2'd0 || cnt_q == 2'd1))
    else $error("hex escape holds two digits");
`endif

endmodule

`default_nettype wire

/* rtl/bed_fifo.sv */
// short queue of decoded entries between front and back end
`default_nettype none

module bed_fifo (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire bed_pkg::bed_entry_t push_entry_i,
  input  wire logic               pop_i,
  output logic                    full_o,
  output logic                    empty_o,
  output bed_pkg::bed_entry_t     head_o
);
  import bed_pkg::*;

  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  bed_entry_t          mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0]     cnt_q;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(FifoDepth))
    else $error("queue fill count out of range");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != CntW'(FifoDepth)) |-> (FifoPtrW'(wr_q - rd_q) == FifoPtrW'(cnt_q)))
    else $error("queue pointers disagree with fill count");
`endif

endmodule

`default_nettype wire

/* rtl/bed_back.sv */
// back end: takes queue entries and sends their bytes one transfer at a time
`default_nettype none

module bed_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               empty_i,
  input  wire bed_pkg::bed_entry_t head_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [7:0]              out_byte_o,
  output logic                    out_last_o
);
  import bed_pkg::*;

  bed_entry_t cur_q;
  logic       valid_q;
  logic       sel_q;
  logic       xfer, done, load;

  assign xfer        = valid_q && out_ready_i;
  assign out_last_o  = !cur_q.pair || sel_q;
  assign done        = xfer && out_last_o;
  assign load        = !valid_q || done;
  assign pop_o       = load && !empty_i;
  assign out_valid_o = valid_q;
  assign out_byte_o  = sel_q ? cur_q.byte1 : cur_q.byte0;

  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= head_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sel_q   <= 1'b0;
    end else begin
      if (load) begin
        valid_q <= !empty_i;
        sel_q   <= 1'b0;
      end else if (xfer) begin
        sel_q <= 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_sel_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_q |-> (valid_q && cur_q.pair))
    else $error("second byte selected on a single-byte entry");
  a_first_then_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (xfer && cur_q.pair && !sel_q) |=> (valid_q && sel_q))
    else $error("second byte of a pair lost");
`endif

endmodule

`default_nettype wire
